// ===== hw/rtl/epd_pkg.sv =====
// Shared constants and control types for the escaped packet deframer.
package epd_pkg;

   localparam int DATA_W           = 8;
   localparam int PAYLOAD_CAPACITY = 64;
   localparam int LEN_W            = $clog2(PAYLOAD_CAPACITY + 1);
   localparam int ADDR_W           = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1;
   localparam int CSR_INDEX_W      = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_CODE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CODE    = CSR_INDEX_W'(1);

   localparam logic [DATA_W-1:0] ESCAPE_CODE_RESET = DATA_W'(16);
   localparam logic [DATA_W-1:0] END_CODE_RESET    = DATA_W'(3);
   localparam logic [DATA_W-1:0] RESTART_CODE      = DATA_W'(0);

   typedef struct packed {
      logic take_byte;
      logic idx_clear;
      logic idx_step;
      logic load_data;
      logic load_empty;
      logic len_clear;
   } cmd_type;

   typedef struct packed {
      logic is_end;
      logic len_zero;
      logic is_last;
      logic slot_free;
   } status_type;

endpackage

// ===== hw/rtl/epd_datapath.sv =====
// Datapath: configuration registers, escape flag, payload store and result register.
module epd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [epd_pkg::DATA_W-1:0]    req_rx_byte,
   input  logic                          csr_valid,
   input  logic [epd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [epd_pkg::DATA_W-1:0]    csr_wdata,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [epd_pkg::DATA_W-1:0]    rsp_data_byte,
   output logic                          rsp_last_of_packet,
   output logic                          rsp_empty_packet,
   input  epd_pkg::cmd_type              cmd,
   output epd_pkg::status_type           status
);

   logic [epd_pkg::DATA_W-1:0] escape_code_ff;
   logic [epd_pkg::DATA_W-1:0] end_code_ff;
   logic                       escape_pending_ff, escape_pending_in;
   logic [epd_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [epd_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [epd_pkg::DATA_W-1:0] rd_data_ff;
   logic [epd_pkg::DATA_W-1:0] store_mem [epd_pkg::PAYLOAD_CAPACITY];
   logic                       store_wr;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [epd_pkg::DATA_W-1:0] rsp_data_ff;
   logic                       rsp_last_ff;
   logic                       rsp_empty_ff;
   logic                       full;

   assign full = (len_ff >= epd_pkg::LEN_W'(epd_pkg::PAYLOAD_CAPACITY));

   assign status.is_end    = escape_pending_ff && (req_rx_byte == end_code_ff);
   assign status.len_zero  = (len_ff == '0);
   assign status.is_last   = ((epd_pkg::LEN_W'(idx_ff) + epd_pkg::LEN_W'(1)) == len_ff);
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   // Byte decode; the end-of-packet case is left to the controller.
   always_comb begin
      escape_pending_in = escape_pending_ff;
      len_in            = len_ff;
      store_wr          = 1'b0;
      if (cmd.take_byte) begin
         if (escape_pending_ff) begin
            escape_pending_in = 1'b0;
            if (req_rx_byte == end_code_ff) begin
               len_in = len_ff;
            end else if (req_rx_byte == epd_pkg::RESTART_CODE) begin
               len_in = '0;
            end else if (full) begin
               len_in = '0;
            end else begin
               store_wr = 1'b1;
               len_in   = len_ff + epd_pkg::LEN_W'(1);
            end
         end else if (req_rx_byte == escape_code_ff) begin
            escape_pending_in = 1'b1;
         end else if (full) begin
            len_in = '0;
         end else begin
            store_wr = 1'b1;
            len_in   = len_ff + epd_pkg::LEN_W'(1);
         end
      end
      if (cmd.len_clear) begin
         len_in = '0;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + epd_pkg::ADDR_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_data || cmd.load_empty) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_code_ff    <= epd_pkg::ESCAPE_CODE_RESET;
         end_code_ff       <= epd_pkg::END_CODE_RESET;
         escape_pending_ff <= 1'b0;
         len_ff            <= '0;
         idx_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == epd_pkg::CSR_ESCAPE_CODE)) begin
            escape_code_ff <= csr_wdata;
         end
         if (csr_valid && (csr_index == epd_pkg::CSR_END_CODE)) begin
            end_code_ff <= csr_wdata;
         end
         escape_pending_ff <= escape_pending_in;
         len_ff            <= len_in;
         idx_ff            <= idx_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[len_ff[epd_pkg::ADDR_W-1:0]] <= req_rx_byte;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_data) begin
         rsp_data_ff  <= rd_data_ff;
         rsp_last_ff  <= status.is_last;
         rsp_empty_ff <= 1'b0;
      end else if (cmd.load_empty) begin
         rsp_data_ff  <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_empty_ff <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_byte      = rsp_data_ff;
   assign rsp_last_of_packet = rsp_last_ff;
   assign rsp_empty_packet   = rsp_empty_ff;

endmodule

// ===== hw/rtl/epd_ctrl.sv =====
// Controller state machine: byte intake and packet readout sequencing.
module epd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  epd_pkg::status_type status,
   output epd_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_EMPTY
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;
   logic      take;

   assign take      = req_valid && req_ready_ff;
   assign req_ready = req_ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take_byte = take;
            if (take && status.is_end) begin
               cmd.idx_clear = 1'b1;
               state_in      = status.len_zero ? ST_EMPTY : ST_READ;
            end
         end
         ST_READ: begin
            // The store read issued from the index lands next cycle.
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.slot_free) begin
               cmd.load_data = 1'b1;
               if (status.is_last) begin
                  cmd.len_clear = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.idx_step = 1'b1;
                  state_in     = ST_READ;
               end
            end
         end
         ST_EMPTY: begin
            if (status.slot_free) begin
               cmd.load_empty = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

endmodule

// ===== hw/rtl/escaped_packet_deframer_unit.sv =====
// Top level of the escaped packet deframer.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_rx_byte
//   rsp       out        rsp_valid/rsp_ready   rsp_data_byte, rsp_last_of_packet,
//                                              rsp_empty_packet
//   csr       in         csr_valid/csr_ready   csr_index, csr_wdata
//
// A byte that does not end a packet leaves the input ready for another. A packet end
// holds off the input while the store is read out, each byte through the registered
// store read, then the result register load; an empty packet yields one result.
// Synchronous reset restores the register defaults and clears the flag and length.
// A stalled result holds the readout; a new byte is taken while the last result waits.
module escaped_packet_deframer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [epd_pkg::DATA_W-1:0]      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [epd_pkg::DATA_W-1:0]      rsp_data_byte,
   output logic                            rsp_last_of_packet,
   output logic                            rsp_empty_packet,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [epd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [epd_pkg::DATA_W-1:0]      csr_wdata
);

   epd_pkg::cmd_type    cmd;
   epd_pkg::status_type status;

   assign csr_ready = !reset;

   epd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   epd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last_of_packet (rsp_last_of_packet),
      .rsp_empty_packet   (rsp_empty_packet),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

// ===== tb/escaped_packet_deframer_unit_tb.sv =====
// Self-checking testbench for the escaped packet deframer: directed frames, random traffic.
module escaped_packet_deframer_unit_tb;

   // Register indexes past the last defined register; writes to them must be ignored.
   localparam logic [epd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_NEXT = epd_pkg::CSR_INDEX_W'(2);
   localparam logic [epd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_TOP  = epd_pkg::CSR_INDEX_W'(255);

   class deframer_scoreboard;
      typedef struct packed {
         logic [epd_pkg::DATA_W-1:0] data_byte;
         logic                       last_of_packet;
         logic                       empty_packet;
      } packet_byte_type;

      logic [epd_pkg::DATA_W-1:0] escape_code;
      logic [epd_pkg::DATA_W-1:0] end_code;
      bit                         escape_armed;
      bit [epd_pkg::LEN_W-1:0]    stored_len;
      logic [epd_pkg::DATA_W-1:0] stored_bytes [epd_pkg::PAYLOAD_CAPACITY];
      packet_byte_type            expected_packet_bytes [$];
      int                         errors;
      int                         bytes_taken;
      int                         results_checked;
      int                         packets_closed;

      function new();
         escape_code     = epd_pkg::ESCAPE_CODE_RESET;
         end_code        = epd_pkg::END_CODE_RESET;
         escape_armed    = 1'b0;
         stored_len      = '0;
         errors          = 0;
         bytes_taken     = 0;
         results_checked = 0;
         packets_closed  = 0;
      endfunction

      function void write_reg(logic [epd_pkg::CSR_INDEX_W-1:0] index,
                              logic [epd_pkg::DATA_W-1:0] value);
         if (index == epd_pkg::CSR_ESCAPE_CODE) begin
            escape_code = value;
         end else if (index == epd_pkg::CSR_END_CODE) begin
            end_code = value;
         end
      endfunction

      // A full store drops the incoming byte and throws the whole packet away.
      function void store_literal(logic [epd_pkg::DATA_W-1:0] b);
         if (stored_len >= epd_pkg::PAYLOAD_CAPACITY) begin
            stored_len = '0;
         end else begin
            stored_bytes[stored_len] = b;
            stored_len = stored_len + 1'b1;
         end
      endfunction

      // Predicts the packet bytes that one received byte releases, if any.
      function void take_rx_byte(logic [epd_pkg::DATA_W-1:0] b);
         packet_byte_type pb;
         bytes_taken++;
         if (escape_armed) begin
            escape_armed = 1'b0;
            if (b == end_code) begin
               packets_closed++;
               if (stored_len == 0) begin
                  pb.data_byte      = '0;
                  pb.last_of_packet = 1'b1;
                  pb.empty_packet   = 1'b1;
                  expected_packet_bytes.push_back(pb);
               end else begin
                  for (int k = 0; k < stored_len; k++) begin
                     pb.data_byte      = stored_bytes[k];
                     pb.last_of_packet = (k == stored_len - 1);
                     pb.empty_packet   = 1'b0;
                     expected_packet_bytes.push_back(pb);
                  end
               end
               stored_len = '0;
            end else if (b == epd_pkg::RESTART_CODE) begin
               stored_len = '0;
            end else begin
               store_literal(b);
            end
         end else if (b == escape_code) begin
            escape_armed = 1'b1;
         end else begin
            store_literal(b);
         end
      endfunction

      function void check_packet_byte(logic [epd_pkg::DATA_W-1:0] data_byte,
                                      logic last_of_packet, logic empty_packet);
         packet_byte_type pb;
         if (expected_packet_bytes.size() == 0) begin
            $error("unexpected packet byte: data_byte %0d, last_of_packet %0b, empty_packet %0b",
                   data_byte, last_of_packet, empty_packet);
            errors++;
            return;
         end
         pb = expected_packet_bytes.pop_front();
         results_checked++;
         if (data_byte !== pb.data_byte) begin
            $error("data_byte mismatch: expected %0d, actual %0d", pb.data_byte, data_byte);
            errors++;
         end
         if (last_of_packet !== pb.last_of_packet) begin
            $error("last_of_packet mismatch: expected %0b, actual %0b",
                   pb.last_of_packet, last_of_packet);
            errors++;
         end
         if (empty_packet !== pb.empty_packet) begin
            $error("empty_packet mismatch: expected %0b, actual %0b",
                   pb.empty_packet, empty_packet);
            errors++;
         end
      endfunction

      function int pending();
         return expected_packet_bytes.size();
      endfunction
   endclass

   logic                            clock              = 1'b0;
   logic                            reset              = 1'b1;
   logic                            req_valid          = 1'b0;
   logic                            req_ready;
   logic [epd_pkg::DATA_W-1:0]      req_rx_byte        = '0;
   logic                            rsp_valid;
   logic                            rsp_ready          = 1'b0;
   logic [epd_pkg::DATA_W-1:0]      rsp_data_byte;
   logic                            rsp_last_of_packet;
   logic                            rsp_empty_packet;
   logic                            csr_valid          = 1'b0;
   logic                            csr_ready;
   logic [epd_pkg::CSR_INDEX_W-1:0] csr_index          = '0;
   logic [epd_pkg::DATA_W-1:0]      csr_wdata          = '0;

   deframer_scoreboard         sb = new();
   logic [epd_pkg::DATA_W-1:0] rx_plan [$];
   bit                         plan_active = 1'b0;
   int                         settings_used = 1;

   escaped_packet_deframer_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last_of_packet (rsp_last_of_packet),
      .rsp_empty_packet   (rsp_empty_packet),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver: switches between always ready, coin flip and mostly stalled, and once
   // holds off for a long stretch while bytes are still being offered.
   int hold_left      = 0;
   bit long_hold_done = 1'b0;
   int ready_mode     = 0;
   int mode_left      = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_packet_byte(rsp_data_byte, rsp_last_of_packet, rsp_empty_packet);
         end
         if (!long_hold_done && plan_active && sb.results_checked >= 40) begin
            long_hold_done = 1'b1;
            hold_left      = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(10, 60);
            end
            mode_left--;
            case (ready_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Appends a well-formed packet with a random payload of len stored bytes,
   // stuffed for the current codes, followed by the end sequence.
   function automatic void plan_packet(int len);
      logic [epd_pkg::DATA_W-1:0] esc;
      logic [epd_pkg::DATA_W-1:0] fin;
      logic [epd_pkg::DATA_W-1:0] b;
      esc = sb.escape_code;
      fin = sb.end_code;
      for (int k = 0; k < len; k++) begin
         b = epd_pkg::DATA_W'($urandom);
         if (b == esc) begin
            // A doubled escape only stands for a literal when it cannot mean end or restart.
            if (esc != fin && esc != epd_pkg::RESTART_CODE) begin
               rx_plan.push_back(esc);
            end else begin
               b = b ^ epd_pkg::DATA_W'(1);
            end
         end
         rx_plan.push_back(b);
      end
      rx_plan.push_back(esc);
      rx_plan.push_back(fin);
   endfunction

   function automatic void plan_traffic(int target);
      int start;
      int pick;
      int n;
      start = rx_plan.size();
      while (rx_plan.size() - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            plan_packet(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
         end else if (pick < 70) begin
            rx_plan.push_back(sb.escape_code);
            rx_plan.push_back(epd_pkg::DATA_W'($urandom));
         end else if (pick < 80) begin
            n = $urandom_range(1, 3);
            repeat (n) rx_plan.push_back(epd_pkg::DATA_W'($urandom));
            rx_plan.push_back(sb.escape_code);
            rx_plan.push_back(epd_pkg::RESTART_CODE);
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) rx_plan.push_back(epd_pkg::DATA_W'($urandom));
         end
      end
      plan_packet($urandom_range(0, 3));
   endfunction

   // Sends the planned bytes in bursts with random gaps in between.
   task automatic send_plan();
      int                         burst_left;
      logic [epd_pkg::DATA_W-1:0] b;
      burst_left  = $urandom_range(1, 8);
      plan_active = 1'b1;
      while (rx_plan.size() != 0) begin
         b = rx_plan.pop_front();
         req_valid   <= 1'b1;
         req_rx_byte <= b;
         do @(posedge clock); while (!req_ready);
         sb.take_rx_byte(b);
         burst_left--;
         if (burst_left == 0 || rx_plan.size() == 0) begin
            req_valid <= 1'b0;
            if (rx_plan.size() != 0) begin
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
         end
      end
      plan_active = 1'b0;
   endtask

   task automatic program_codes(logic [epd_pkg::DATA_W-1:0] esc,
                                logic [epd_pkg::DATA_W-1:0] fin, bit touch_spare);
      logic [epd_pkg::CSR_INDEX_W-1:0] idx_list [$];
      logic [epd_pkg::DATA_W-1:0]      val_list [$];
      if (touch_spare) begin
         idx_list.push_back(CSR_SPARE_NEXT);
         val_list.push_back(epd_pkg::DATA_W'($urandom));
         idx_list.push_back(CSR_SPARE_TOP);
         val_list.push_back(epd_pkg::DATA_W'($urandom));
      end
      idx_list.push_back(epd_pkg::CSR_ESCAPE_CODE);
      val_list.push_back(esc);
      idx_list.push_back(epd_pkg::CSR_END_CODE);
      val_list.push_back(fin);
      foreach (idx_list[i]) begin
         csr_valid <= 1'b1;
         csr_index <= idx_list[i];
         csr_wdata <= val_list[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx_list[i], val_list[i]);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Bytes that close no packet leave nothing to wait for, so keep clocking after the queue empties.
   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [epd_pkg::DATA_W-1:0] esc_list [6];
      logic [epd_pkg::DATA_W-1:0] fin_list [6];
      esc_list = '{epd_pkg::DATA_W'(0), epd_pkg::DATA_W'(255), epd_pkg::DATA_W'(8'h7E),
                   epd_pkg::DATA_W'(0), epd_pkg::DATA_W'($urandom),
                   epd_pkg::ESCAPE_CODE_RESET};
      fin_list = '{epd_pkg::DATA_W'(255), epd_pkg::DATA_W'(0), epd_pkg::DATA_W'(8'h7E),
                   epd_pkg::DATA_W'(0), epd_pkg::DATA_W'($urandom),
                   epd_pkg::END_CODE_RESET};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed frames with the default codes: an empty packet, extreme bytes with a
      // raw end code and a doubled escape, a restart, and an escaped ordinary byte.
      rx_plan = '{epd_pkg::ESCAPE_CODE_RESET, epd_pkg::END_CODE_RESET,
                  8'h00, 8'hFF, epd_pkg::END_CODE_RESET,
                  epd_pkg::ESCAPE_CODE_RESET, epd_pkg::ESCAPE_CODE_RESET,
                  epd_pkg::ESCAPE_CODE_RESET, epd_pkg::END_CODE_RESET,
                  8'h55, epd_pkg::ESCAPE_CODE_RESET, epd_pkg::RESTART_CODE, 8'hAA,
                  epd_pkg::ESCAPE_CODE_RESET, epd_pkg::END_CODE_RESET,
                  epd_pkg::ESCAPE_CODE_RESET, 8'h80,
                  epd_pkg::ESCAPE_CODE_RESET, epd_pkg::END_CODE_RESET};
      send_plan();
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         program_codes(esc_list[p], fin_list[p], p == 4);
         if (p == 5) begin
            // One packet that fills the store exactly, one that overflows it.
            plan_packet(epd_pkg::PAYLOAD_CAPACITY);
            plan_packet(epd_pkg::PAYLOAD_CAPACITY + 1);
         end
         plan_traffic(12);
         send_plan();
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected packet bytes never arrived", sb.pending());
         sb.errors++;
      end
      $display("Sent %0d received bytes under %0d code settings; %0d packets closed.",
               sb.bytes_taken, settings_used, sb.packets_closed);
      $display("Checked %0d packet bytes with random gaps, stalls and one long hold-off.",
               sb.results_checked);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
